>>> src/ihc_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 header check package
// Shared types and constants for the IPv4 header check block.
// ----------------------------------------------------------------------------
package ihc_pkg;

  localparam int LOCAL_ADDR_COUNT = 4;
  localparam int NUM_ADDR_REGS    = 4;
  localparam int CFG_INDEX_W      = 3;
  localparam int CFG_DATA_W       = 32;

  localparam logic [3:0]  IPV4_VERSION   = 4'd4;
  localparam logic [3:0]  MIN_HEADER_LEN = 4'd5;
  localparam logic [15:0] SUM_ALL_ONES   = 16'hFFFF;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;

  localparam logic [4:0] WORD_TTL_PROTO = 5'd4;
  localparam logic [4:0] WORD_DEST_HIGH = 5'd8;
  localparam logic [4:0] WORD_DEST_LOW  = 5'd9;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LOCAL_ADDR_A = 3'd0,
    REG_LOCAL_ADDR_B = 3'd1,
    REG_LOCAL_ADDR_C = 3'd2,
    REG_LOCAL_ADDR_D = 3'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT       = 3'd0,
    VERDICT_BAD_VERSION  = 3'd1,
    VERDICT_SHORT_HEADER = 3'd2,
    VERDICT_TTL_ZERO     = 3'd3,
    VERDICT_BAD_CHECKSUM = 3'd4,
    VERDICT_NOT_LOCAL    = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [15:0] header_word;
    logic        first_word;
  } hdr_in_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  protocol;
    logic        is_icmp;
  } hdr_out_t;

endpackage

>>> src/ipv4_header_check.sv
// ----------------------------------------------------------------------------
// IPv4 header check
// Validates IPv4 headers that arrive as 16-bit words and reports a verdict.
// ----------------------------------------------------------------------------
// The input channel takes one header word per cycle in network order while
// in_ready is high, with first_word set on the word that opens a header. A
// bad version or short header length gives a verdict for the first word
// itself; otherwise the verdict, protocol and ICMP flag come with the
// header's last word. Words that arrive while no header is open are dropped
// without a result. A word is taken in a cycle in which it is offered while
// in_ready is high, and its verdict, if any, is registered into the result
// buffer, whose head register drives the output.
// Results pass through a two-entry buffer, so input keeps flowing while one
// verdict waits; the input stalls only when both entries are held.
// The user must write the local addresses through the configuration port
// while the block is idle; the block does not enforce it. Reset clears all
// state, buffer and addresses, leaving the block idle for a first word.
// ----------------------------------------------------------------------------
module ipv4_header_check (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ihc_pkg::hdr_in_t                   in_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ihc_pkg::hdr_out_t                  out_word,
  input  logic                               cfg_write,
  input  logic [ihc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ihc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [31:0] local_addr [ihc_pkg::NUM_ADDR_REGS];

  logic [4:0]  word_index;
  logic [4:0]  header_words;
  logic [15:0] running_sum;
  logic        ttl_was_zero;
  logic [7:0]  protocol_seen;
  logic [15:0] dest_high;
  logic        header_active;
  logic        dest_match;

  logic [4:0]  word_index_next;
  logic [4:0]  header_words_next;
  logic [15:0] running_sum_next;
  logic        ttl_was_zero_next;
  logic [7:0]  protocol_seen_next;
  logic [15:0] dest_high_next;
  logic        header_active_next;
  logic        dest_match_next;

  logic              accept;
  logic              buf_full;
  logic              res_valid;
  ihc_pkg::hdr_out_t res_word;
  logic [16:0]       sum_wide;
  logic [15:0]       sum_fold;
  logic              addr_hit;
  logic [5:0]        idx_inc;
  logic [3:0]        version;
  logic [3:0]        ihl;

  assign in_ready = !buf_full;
  assign accept   = in_valid && in_ready;
  assign version  = in_word.header_word[15:12];
  assign ihl      = in_word.header_word[11:8];
  assign sum_wide = {1'b0, running_sum} + {1'b0, in_word.header_word};
  assign sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};
  assign idx_inc  = {1'b0, word_index} + 6'd1;

  always_comb begin
    addr_hit = 1'b0;
    for (int i = 0; i < ihc_pkg::LOCAL_ADDR_COUNT; i++) begin
      if (local_addr[i] == {dest_high, in_word.header_word}) begin
        addr_hit = 1'b1;
      end
    end
  end

  always_comb begin
    word_index_next    = word_index;
    header_words_next  = header_words;
    running_sum_next   = running_sum;
    ttl_was_zero_next  = ttl_was_zero;
    protocol_seen_next = protocol_seen;
    dest_high_next     = dest_high;
    header_active_next = header_active;
    dest_match_next    = dest_match;
    res_valid          = 1'b0;
    res_word.verdict   = ihc_pkg::VERDICT_ACCEPT;
    res_word.protocol  = 8'd0;
    res_word.is_icmp   = 1'b0;

    if (in_word.first_word) begin
      header_active_next = 1'b0;
      if (version != ihc_pkg::IPV4_VERSION) begin
        res_valid        = 1'b1;
        res_word.verdict = ihc_pkg::VERDICT_BAD_VERSION;
      end else if (ihl < ihc_pkg::MIN_HEADER_LEN) begin
        res_valid        = 1'b1;
        res_word.verdict = ihc_pkg::VERDICT_SHORT_HEADER;
      end else begin
        header_words_next  = {ihl, 1'b0};
        running_sum_next   = in_word.header_word;
        word_index_next    = 5'd1;
        ttl_was_zero_next  = 1'b0;
        protocol_seen_next = 8'd0;
        dest_high_next     = 16'd0;
        dest_match_next    = 1'b0;
        header_active_next = 1'b1;
      end
    end else if (header_active) begin
      running_sum_next = sum_fold;
      if (word_index == ihc_pkg::WORD_TTL_PROTO) begin
        ttl_was_zero_next  = (in_word.header_word[15:8] == 8'd0);
        protocol_seen_next = in_word.header_word[7:0];
      end else if (word_index == ihc_pkg::WORD_DEST_HIGH) begin
        dest_high_next = in_word.header_word;
      end else if (word_index == ihc_pkg::WORD_DEST_LOW) begin
        dest_match_next = addr_hit;
      end

      if (idx_inc < {1'b0, header_words}) begin
        word_index_next = idx_inc[4:0];
      end else begin
        header_active_next = 1'b0;
        res_valid          = 1'b1;
        res_word.protocol  = protocol_seen_next;
        if (ttl_was_zero_next) begin
          res_word.verdict = ihc_pkg::VERDICT_TTL_ZERO;
        end else if (running_sum_next != ihc_pkg::SUM_ALL_ONES) begin
          res_word.verdict = ihc_pkg::VERDICT_BAD_CHECKSUM;
        end else if (!dest_match_next) begin
          res_word.verdict = ihc_pkg::VERDICT_NOT_LOCAL;
        end else begin
          res_word.verdict = ihc_pkg::VERDICT_ACCEPT;
          res_word.is_icmp = (protocol_seen_next == ihc_pkg::PROTO_ICMP);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index    <= 5'd0;
      header_words  <= 5'd0;
      running_sum   <= 16'd0;
      ttl_was_zero  <= 1'b0;
      protocol_seen <= 8'd0;
      dest_high     <= 16'd0;
      header_active <= 1'b0;
      dest_match    <= 1'b0;
    end else if (accept) begin
      word_index    <= word_index_next;
      header_words  <= header_words_next;
      running_sum   <= running_sum_next;
      ttl_was_zero  <= ttl_was_zero_next;
      protocol_seen <= protocol_seen_next;
      dest_high     <= dest_high_next;
      header_active <= header_active_next;
      dest_match    <= dest_match_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ihc_pkg::NUM_ADDR_REGS; i++) begin
        local_addr[i] <= 32'd0;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        ihc_pkg::REG_LOCAL_ADDR_A: local_addr[0] <= cfg_data;
        ihc_pkg::REG_LOCAL_ADDR_B: local_addr[1] <= cfg_data;
        ihc_pkg::REG_LOCAL_ADDR_C: local_addr[2] <= cfg_data;
        ihc_pkg::REG_LOCAL_ADDR_D: local_addr[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  ihc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_word (res_word),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

`ifndef ASSERT_OFF
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    header_active |-> (word_index < header_words))
    else $error("word index ran past the header length");

  a_len_min: assert property (@(posedge clk) disable iff (rst)
    header_active |-> (header_words >= {ihc_pkg::MIN_HEADER_LEN, 1'b0}))
    else $error("open header shorter than the minimum length");

  a_icmp_only_accept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.is_icmp) |->
      (out_word.verdict == ihc_pkg::VERDICT_ACCEPT &&
       out_word.protocol == ihc_pkg::PROTO_ICMP))
    else $error("ICMP flag on a word that is not an accepted ICMP header");

  a_bad_first_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && in_word.first_word && version != ihc_pkg::IPV4_VERSION) |=>
      (!header_active && out_valid))
    else $error("bad version did not close the header with a verdict");

  a_stall_means_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no verdict pending");
`endif

endmodule

>>> src/ihc_out_buf.sv
// ----------------------------------------------------------------------------
// IPv4 header check result buffer
// Two-entry output buffer: an output register and a skid register.
// ----------------------------------------------------------------------------
module ihc_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ihc_pkg::hdr_out_t push_word,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output ihc_pkg::hdr_out_t out_word
);

  logic              head_valid;
  logic              skid_valid;
  ihc_pkg::hdr_out_t head;
  ihc_pkg::hdr_out_t skid;
  logic              pop;

  assign pop       = head_valid && out_ready;
  assign full      = skid_valid;
  assign out_valid = head_valid;
  assign out_word  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        head       <= skid;
        skid_valid <= push;
        skid       <= push_word;
      end else begin
        head_valid <= push;
        head       <= push_word;
      end
    end else if (push) begin
      if (!head_valid) begin
        head_valid <= 1'b1;
        head       <= push_word;
      end else begin
        skid_valid <= 1'b1;
        skid       <= push_word;
      end
    end
  end

endmodule
